// File: sv/gsf_pkg.sv
// ----------------------------------------------------------------------------
// gsf_pkg
// Shared constants, register codes and job types of the gaussian smoothing fir.
// ----------------------------------------------------------------------------
package gsf_pkg;

	localparam int MAX_TAPS       = 32;
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 16;

	localparam int TAPS_W      = 6;
	localparam int COEF_IDX_W  = 5;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	// register index taken from paddr[2]
	localparam logic REG_TAPS = 1'b0;
	localparam logic REG_EDGE = 1'b1;

	localparam logic [TAPS_W-1:0] TAPS_RESET = '0;
	localparam logic              EDGE_RESET = 1'b1;

	// input item kind codes
	localparam logic KIND_COEF   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		JOB_COEF,
		JOB_FILT,
		JOB_PASS
	} job_kind_t;

	typedef struct packed {
		job_kind_t               kind;
		logic                    last_out;
		logic [COEF_IDX_W-1:0]   coef_idx;
	} job_ctl_t;

	typedef struct packed {
		logic flushing;
		logic push;
	} front_sts_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// File: sv/gsf_ifs.sv
// ----------------------------------------------------------------------------
// gsf input and output channels
// Valid/ready channels carrying sample or coefficient items and filter results.
// ----------------------------------------------------------------------------
interface gsf_in_if #(
	parameter int SAMPLE_BITS    = gsf_pkg::SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = gsf_pkg::COEF_FRAC_BITS
);
	logic                                 valid;
	logic                                 ready;
	logic                                 kind;
	logic signed [SAMPLE_BITS-1:0]        sample;
	logic                                 last;
	logic [gsf_pkg::COEF_IDX_W-1:0]       coef_index;
	logic [COEF_FRAC_BITS:0]              coef_value;

	modport source (output valid, kind, sample, last, coef_index, coef_value, input ready);
	modport sink   (input valid, kind, sample, last, coef_index, coef_value, output ready);
endinterface

interface gsf_out_if #(
	parameter int SAMPLE_BITS = gsf_pkg::SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] smoothed;
	logic                          last_out;

	modport source (output valid, smoothed, last_out, input ready);
	modport sink   (input valid, smoothed, last_out, output ready);
endinterface

// File: sv/gsf_front.sv
// ----------------------------------------------------------------------------
// gsf_front
// Accepts items, keeps the sample window and sequence state, issues jobs.
// ----------------------------------------------------------------------------
module gsf_front #(
	parameter int MAX_TAPS       = gsf_pkg::MAX_TAPS,
	parameter int SAMPLE_BITS    = gsf_pkg::SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = gsf_pkg::COEF_FRAC_BITS,
	localparam int W_W           = $clog2(MAX_TAPS + 1),
	localparam int WIN_W         = MAX_TAPS * SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gsf_in_if.sink                        in_ch,
	input  logic [W_W-1:0]                w,
	input  logic                          q_full,
	output gsf_pkg::job_ctl_t             job_ctl,
	output logic [W_W-1:0]                job_lag,
	output logic [W_W-1:0]                job_seen,
	output logic signed [SAMPLE_BITS-1:0] job_first,
	output logic [COEF_FRAC_BITS:0]       job_coef,
	output logic [WIN_W-1:0]              job_win,
	output gsf_pkg::front_sts_t           sts
);

	logic [WIN_W-1:0]              win_q, win_n;
	logic [W_W-1:0]                seen_q, seen_n, lag_q, dly;
	logic signed [SAMPLE_BITS-1:0] first_q, first_n;
	logic                          flush_q;
	logic                          fire, idx_ok, flush_push, flush_step;

	// outputs still pending behind the newest sample
	assign dly        = w - W_W'(1) - (w >> 1);
	assign in_ch.ready = !flush_q && !q_full;
	assign fire       = in_ch.valid && in_ch.ready;
	assign idx_ok     = (int'(in_ch.coef_index) < MAX_TAPS);
	assign win_n      = (win_q << SAMPLE_BITS) | WIN_W'($unsigned(in_ch.sample));
	assign seen_n     = (int'(seen_q) < MAX_TAPS) ? seen_q + W_W'(1) : seen_q;
	assign first_n    = (seen_q == '0) ? in_ch.sample : first_q;
	assign flush_push = flush_q && (lag_q < seen_q);
	assign flush_step = flush_q && (!flush_push || !q_full);

	always_comb begin
		job_ctl.kind     = gsf_pkg::JOB_FILT;
		job_ctl.last_out = 1'b0;
		job_ctl.coef_idx = in_ch.coef_index;
		job_lag          = dly;
		job_seen         = seen_n;
		job_first        = first_n;
		job_coef         = in_ch.coef_value;
		job_win          = win_n;
		sts.push         = 1'b0;
		sts.flushing     = flush_q;
		if (flush_q) begin
			job_lag          = lag_q;
			job_seen         = seen_q;
			job_first        = first_q;
			job_win          = win_q;
			job_ctl.last_out = (lag_q == '0);
			sts.push         = flush_push && !q_full;
		end else if (fire) begin
			case (in_ch.kind)
				gsf_pkg::KIND_COEF: begin
					job_ctl.kind = gsf_pkg::JOB_COEF;
					sts.push     = idx_ok;
				end
				gsf_pkg::KIND_SAMPLE: begin
					if (w == '0) begin
						job_ctl.kind     = gsf_pkg::JOB_PASS;
						job_ctl.last_out = in_ch.last;
						job_first        = in_ch.sample;
						sts.push         = 1'b1;
					end else if (!in_ch.last) begin
						sts.push = (seen_n > dly);
					end
				end
				default: sts.push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire && in_ch.kind == gsf_pkg::KIND_SAMPLE) begin
			win_q <= win_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			first_q <= '0;
			flush_q <= 1'b0;
			lag_q   <= '0;
		end else begin
			if (fire && in_ch.kind == gsf_pkg::KIND_SAMPLE) begin
				first_q <= first_n;
				if (in_ch.last && w == '0) begin
					seen_q <= '0;
				end else begin
					seen_q <= seen_n;
				end
				if (in_ch.last && w != '0) begin
					flush_q <= 1'b1;
					lag_q   <= dly;
				end
			end
			if (flush_step) begin
				if (lag_q == '0) begin
					flush_q <= 1'b0;
					seen_q  <= '0;
				end else begin
					lag_q <= lag_q - W_W'(1);
				end
			end
		end
	end

endmodule

// File: sv/gsf_queue.sv
// ----------------------------------------------------------------------------
// gsf_queue
// Two-entry job queue between the front and the filter datapath.
// ----------------------------------------------------------------------------
module gsf_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] din,
	input  logic              pop,
	output logic [DATA_W-1:0] dout,
	output logic              full,
	output logic              empty
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wr_q, rd_q;
	logic [1:0]        cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: sv/gsf_back.sv
// ----------------------------------------------------------------------------
// gsf_back
// Kernel store, operand build with edge padding, parallel multipliers,
// registered adder tree, rounding and saturation, output register.
// ----------------------------------------------------------------------------
module gsf_back #(
	parameter int MAX_TAPS       = gsf_pkg::MAX_TAPS,
	parameter int SAMPLE_BITS    = gsf_pkg::SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = gsf_pkg::COEF_FRAC_BITS,
	localparam int W_W           = $clog2(MAX_TAPS + 1),
	localparam int WIN_W         = MAX_TAPS * SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  gsf_pkg::job_ctl_t             job_ctl,
	input  logic [W_W-1:0]                job_lag,
	input  logic [W_W-1:0]                job_seen,
	input  logic signed [SAMPLE_BITS-1:0] job_first,
	input  logic [COEF_FRAC_BITS:0]       job_coef,
	input  logic [WIN_W-1:0]              job_win,
	input  logic [W_W-1:0]                w,
	input  logic                          edge_mode,
	output logic                          pop,
	gsf_out_if.source                     out_ch
);

	localparam int LVL   = $clog2(MAX_TAPS);
	localparam int TN    = 1 << LVL;
	localparam int IDX_W = gsf_pkg::max_int(LVL, 1);
	localparam int ACC_W = SAMPLE_BITS + COEF_FRAC_BITS + 2 + LVL;
	localparam int Q_W   = ACC_W - COEF_FRAC_BITS;
	localparam int TW    = TN * SAMPLE_BITS;
	localparam logic [COEF_FRAC_BITS:0] ONE = (COEF_FRAC_BITS + 1)'(1) << COEF_FRAC_BITS;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [Q_W-1:0]   SMAX = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [Q_W-1:0]   SMIN = -(Q_W'(1) << (SAMPLE_BITS - 1));

	logic [COEF_FRAC_BITS:0]       kern_q [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] op_s1  [TN];
	logic [COEF_FRAC_BITS:0]       kc_s1  [TN];
	logic signed [SAMPLE_BITS-1:0] op_n   [TN];
	logic [COEF_FRAC_BITS:0]       kc_n   [TN];
	logic signed [ACC_W-1:0]       tree_q [LVL+1][TN];
	logic [LVL:0]                  vld_q, last_q;
	logic                          vld_s1, last_s1, en;
	logic                          out_vld_q, out_last_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic [TW-1:0]                 rev, shifted;
	logic [W_W-1:0]                base;
	logic signed [ACC_W-1:0]       rnd;
	logic signed [Q_W-1:0]         qv;
	logic signed [SAMPLE_BITS-1:0] sat;

	assign en  = !out_vld_q || out_ch.ready;
	assign pop = en && !q_empty;

	// window newest-first reversed, then one barrel shift lines up every tap
	assign base = job_lag + (w >> 1);

	always_comb begin
		logic signed [W_W+1:0] age;
		rev = '0;
		for (int j = 0; j < MAX_TAPS; j++) begin
			rev[j*SAMPLE_BITS +: SAMPLE_BITS] = job_win[(MAX_TAPS-1-j)*SAMPLE_BITS +: SAMPLE_BITS];
		end
		shifted = rev >> ((MAX_TAPS - 1 - int'(base)) * SAMPLE_BITS);
		for (int j = 0; j < TN; j++) begin
			age     = $signed({2'b00, base}) - (W_W+2)'(j);
			op_n[j] = '0;
			kc_n[j] = '0;
			if (j < MAX_TAPS) begin
				case (job_ctl.kind)
					gsf_pkg::JOB_PASS: begin
						if (j == 0) begin
							op_n[j] = job_first;
							kc_n[j] = ONE;
						end
					end
					gsf_pkg::JOB_FILT: begin
						if (j < int'(w)) begin
							kc_n[j] = kern_q[j];
							if (age < 0) begin
								op_n[j] = edge_mode ? $signed(job_win[SAMPLE_BITS-1:0]) : '0;
							end else if (age >= $signed({2'b00, job_seen})) begin
								op_n[j] = edge_mode ? job_first : '0;
							end else begin
								op_n[j] = $signed(shifted[j*SAMPLE_BITS +: SAMPLE_BITS]);
							end
						end
					end
					default: op_n[j] = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && job_ctl.kind == gsf_pkg::JOB_COEF) begin
			kern_q[IDX_W'(job_ctl.coef_idx)] <= job_coef;
		end
		if (en) begin
			for (int j = 0; j < TN; j++) begin
				op_s1[j]     <= op_n[j];
				kc_s1[j]     <= kc_n[j];
				tree_q[0][j] <= ACC_W'($signed(op_s1[j]) * $signed({1'b0, kc_s1[j]}));
			end
			for (int lv = 1; lv <= LVL; lv++) begin
				for (int i = 0; i < (TN >> lv); i++) begin
					tree_q[lv][i] <= tree_q[lv-1][2*i] + tree_q[lv-1][2*i+1];
				end
			end
			out_data_q <= sat;
			out_last_q <= last_q[LVL];
			last_s1    <= job_ctl.last_out;
			last_q     <= {last_q[LVL-1:0], last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= pop && job_ctl.kind != gsf_pkg::JOB_COEF;
			vld_q     <= {vld_q[LVL-1:0], vld_s1};
			out_vld_q <= vld_q[LVL];
		end
	end

	// round half up, arithmetic shift floors, then clamp
	always_comb begin
		rnd = tree_q[LVL][0] + HALF;
		qv  = Q_W'(rnd >>> COEF_FRAC_BITS);
		if (qv > SMAX) begin
			sat = SAMPLE_BITS'(SMAX);
		end else if (qv < SMIN) begin
			sat = SAMPLE_BITS'(SMIN);
		end else begin
			sat = SAMPLE_BITS'(qv);
		end
	end

	assign out_ch.valid    = out_vld_q;
	assign out_ch.smoothed = out_data_q;
	assign out_ch.last_out = out_last_q;

endmodule

// File: sv/gaussian_smoothing_fir_unit.sv
// path: job queue, operand register, product register, adder tree levels, output register
// throughput: one item per cycle (parallel multipliers, adder tree) unless queue full or flushing
// a last sample with w nonzero holds the input while the flush issues
// reset clears sequence state, queue and pipeline valids; taps_in_use 0, edge_mode 1
// kernel and sample window contents are undefined until written
// ----------------------------------------------------------------------------
// gaussian_smoothing_fir_unit
// Centered fir smoother with zero or repeat edge padding and apb registers.
// ----------------------------------------------------------------------------
module gaussian_smoothing_fir_unit #(
	parameter int MAX_TAPS       = gsf_pkg::MAX_TAPS,
	parameter int SAMPLE_BITS    = gsf_pkg::SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = gsf_pkg::COEF_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	gsf_in_if.sink                          in_ch,
	gsf_out_if.source                       out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gsf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [gsf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [gsf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int W_W   = $clog2(MAX_TAPS + 1);
	localparam int WIN_W = MAX_TAPS * SAMPLE_BITS;
	localparam int CMP_W = gsf_pkg::max_int(gsf_pkg::TAPS_W, W_W);
	localparam int CTL_W = $bits(gsf_pkg::job_ctl_t);
	localparam int QW    = CTL_W + 2 * W_W + SAMPLE_BITS + COEF_FRAC_BITS + 1 + WIN_W;

	logic [gsf_pkg::TAPS_W-1:0]    taps_q;
	logic                          edge_q;
	logic [CMP_W-1:0]              taps_ext;
	logic [W_W-1:0]                w;
	logic                          cfg_wr;

	gsf_pkg::job_ctl_t             f_ctl, b_ctl;
	logic [W_W-1:0]                f_lag, f_seen, b_lag, b_seen;
	logic signed [SAMPLE_BITS-1:0] f_first, b_first;
	logic [COEF_FRAC_BITS:0]       f_coef, b_coef;
	logic [WIN_W-1:0]              f_win, b_win;
	gsf_pkg::front_sts_t           f_sts;
	logic [QW-1:0]                 q_dout;
	logic                          q_full, q_empty, q_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= gsf_pkg::TAPS_RESET;
			edge_q <= gsf_pkg::EDGE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				gsf_pkg::REG_TAPS: taps_q <= pwdata[gsf_pkg::TAPS_W-1:0];
				gsf_pkg::REG_EDGE: edge_q <= pwdata[0];
				default:           edge_q <= edge_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			gsf_pkg::REG_TAPS: prdata = gsf_pkg::APB_DATA_W'(taps_q);
			gsf_pkg::REG_EDGE: prdata = gsf_pkg::APB_DATA_W'(edge_q);
			default:           prdata = '0;
		endcase
	end

	// window length clamps to the tap count built
	assign taps_ext = CMP_W'(taps_q);
	assign w = (taps_ext > CMP_W'(MAX_TAPS)) ? W_W'(MAX_TAPS) : W_W'(taps_ext);

	gsf_front #(
		.MAX_TAPS       (MAX_TAPS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.w         (w),
		.q_full    (q_full),
		.job_ctl   (f_ctl),
		.job_lag   (f_lag),
		.job_seen  (f_seen),
		.job_first (f_first),
		.job_coef  (f_coef),
		.job_win   (f_win),
		.sts       (f_sts)
	);

	gsf_queue #(
		.DATA_W (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_sts.push),
		.din    ({f_ctl, f_lag, f_seen, f_first, f_coef, f_win}),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {b_ctl, b_lag, b_seen, b_first, b_coef, b_win} = q_dout;

	gsf_back #(
		.MAX_TAPS       (MAX_TAPS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.job_ctl   (b_ctl),
		.job_lag   (b_lag),
		.job_seen  (b_seen),
		.job_first (b_first),
		.job_coef  (b_coef),
		.job_win   (b_win),
		.w         (w),
		.edge_mode (edge_q),
		.pop       (q_pop),
		.out_ch    (out_ch)
	);

	// front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(f_sts.push && q_full))
		else $error("job pushed into full queue");

	// no new transaction is taken while a flush is issuing
	a_flush_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		f_sts.flushing |-> !in_ch.ready)
		else $error("input ready during flush");

	// an empty queue is never popped
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");

endmodule
